// ===== hdl/pah_pkg.sv =====
// Package for the publish acknowledgement handshake block.
// Holds the event, transmit, status and register codes, widths and the result type.
// Depends on nothing; every other file of the block imports it.
package pah_pkg;

  // Width of the transmission counter.
  localparam int unsigned AttemptWidth = 8;
  localparam int unsigned LimitWidth   = 8;
  localparam int unsigned CmpWidth     = (AttemptWidth > LimitWidth) ? AttemptWidth : LimitWidth;
  localparam logic [AttemptWidth-1:0] CntMax = {AttemptWidth{1'b1}};

  localparam int unsigned PidWidth    = 16;
  localparam int unsigned ReasonWidth = 8;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgWidth    = 8;

  // Reason codes at or above this value are failures.
  localparam logic [ReasonWidth-1:0] ReasonFail = 8'h80;

  typedef enum logic [2:0] {
    KIND_START    = 3'd0,
    KIND_ACK      = 3'd1,
    KIND_RECACK   = 3'd2,
    KIND_COMPACK  = 3'd3,
    KIND_TIMEOUT  = 3'd4,
    KIND_CANCEL   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    TX_NONE    = 2'd0,
    TX_PUBLISH = 2'd1,
    TX_DUP     = 2'd2,
    TX_RELEASE = 2'd3
  } tx_kind_e;

  typedef enum logic [2:0] {
    ST_PENDING  = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_PROTO    = 3'd2,
    ST_TIMEOUT  = 3'd3,
    ST_INTERNAL = 3'd4,
    ST_REJECTED = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_QOS          = 2'd0,
    REG_ATTEMPT      = 2'd1,
    REG_PROBLEM_INFO = 2'd2,
    REG_ALIAS        = 2'd3
  } cfg_reg_e;

  // QoS codes.
  localparam logic [1:0] Qos0 = 2'd0;
  localparam logic [1:0] Qos1 = 2'd1;
  localparam logic [1:0] Qos2 = 2'd2;
  localparam logic [1:0] Qos3 = 2'd3;

  typedef struct packed {
    tx_kind_e               tx_kind;
    logic [PidWidth-1:0]    tx_packet_id;
    logic                   finished;
    logic                   report;
    status_e                status;
    logic                   response_valid;
    logic [ReasonWidth-1:0] response_reason;
    logic                   disconnect;
    logic                   confirm_alias;
    logic                   timer_restart;
  } result_t;

endpackage

// ===== hdl/pah_evt_if.sv =====
// Event channel of the publish acknowledgement handshake block.
// Carries valid, ready and one event item; depends on pah_pkg.
interface pah_evt_if;
  import pah_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [2:0]             kind;
  logic [PidWidth-1:0]    packet_id;
  logic                   reason_present;
  logic [ReasonWidth-1:0] reason_code;
  logic                   props_error;
  logic                   has_reason_text;
  logic                   has_user_props;
  logic                   link_ready;

  modport source (
    output valid, kind, packet_id, reason_present, reason_code, props_error,
           has_reason_text, has_user_props, link_ready,
    input  ready
  );

  modport sink (
    input  valid, kind, packet_id, reason_present, reason_code, props_error,
           has_reason_text, has_user_props, link_ready,
    output ready
  );
endinterface

// ===== hdl/pah_res_if.sv =====
// Result channel of the publish acknowledgement handshake block.
// Carries valid, ready and one result item; depends on pah_pkg.
interface pah_res_if;
  import pah_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [1:0]             tx_kind;
  logic [PidWidth-1:0]    tx_packet_id;
  logic                   finished;
  logic                   report;
  logic [2:0]             status;
  logic                   response_valid;
  logic [ReasonWidth-1:0] response_reason;
  logic                   disconnect;
  logic                   confirm_alias;
  logic                   timer_restart;

  modport source (
    output valid, tx_kind, tx_packet_id, finished, report, status, response_valid,
           response_reason, disconnect, confirm_alias, timer_restart,
    input  ready
  );

  modport sink (
    input  valid, tx_kind, tx_packet_id, finished, report, status, response_valid,
           response_reason, disconnect, confirm_alias, timer_restart,
    output ready
  );
endinterface

// ===== hdl/publish_ack_handshake.sv =====
// Top level of the publish acknowledgement handshake block (sender side).
// Depends on pah_pkg, pah_evt_if and pah_res_if.

// The block runs the sender side of a QoS 0, 1 or 2 publish exchange. Every event item
// accepted on evt_i gives exactly one result item on res_o. Events flow at one item per
// clock cycle while res_o takes the results: an item is captured in an input register,
// decoded by one level of compares and counter updates against the exchange state, and
// the result lands in an output register, from which res_o offers it. The input register
// empties whenever the output register is free or being drained, so a waiting result
// holds back the next event only once the input register is full as well. Configuration
// is written through cfg_we_i, cfg_idx_i and cfg_data_i and is meant to be changed only
// while no event is in flight; the QoS level is read live by every event.
module publish_ack_handshake (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  pah_evt_if.sink                            evt_i,
  pah_res_if.source                          res_o,
  input  logic                               cfg_we_i,
  input  logic [pah_pkg::CfgIdxWidth-1:0]    cfg_idx_i,
  input  logic [pah_pkg::CfgWidth-1:0]       cfg_data_i
);
  import pah_pkg::*;

  // Configuration registers.
  logic [1:0]            qos_q;
  logic [LimitWidth-1:0] limit_q;
  logic                  pia_q;
  logic                  alias_q;

  // Input register.
  logic                   in_valid_q;
  logic [2:0]             in_kind_q;
  logic [PidWidth-1:0]    in_pid_q;
  logic                   in_rp_q;
  logic [ReasonWidth-1:0] in_rc_q;
  logic                   in_perr_q;
  logic                   in_text_q;
  logic                   in_user_q;
  logic                   in_link_q;

  // Exchange state.
  logic                    busy_q, busy_d;
  logic                    gra_q, gra_d;
  logic [AttemptWidth-1:0] sends_q, sends_d;
  logic [PidWidth-1:0]     held_pid_q, held_pid_d;
  logic [ReasonWidth-1:0]  held_reason_q, held_reason_d;

  // Result register.
  logic    res_valid_q;
  result_t res_q, res_d;

  logic in_accept;
  logic proc_fire;

  // An item moves from the input register to the result register when the latter is
  // empty or its item is being taken in the same cycle.
  assign proc_fire  = in_valid_q && (!res_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || proc_fire;
  assign in_accept  = evt_i.valid && evt_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qos_q   <= Qos0;
      limit_q <= LimitWidth'(2);
      pia_q   <= 1'b1;
      alias_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_QOS:          qos_q   <= cfg_data_i[1:0];
        REG_ATTEMPT:      limit_q <= cfg_data_i[LimitWidth-1:0];
        REG_PROBLEM_INFO: pia_q   <= cfg_data_i[0];
        REG_ALIAS:        alias_q <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_accept) begin
      in_valid_q <= 1'b1;
    end else if (proc_fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_kind_q <= evt_i.kind;
      in_pid_q  <= evt_i.packet_id;
      in_rp_q   <= evt_i.reason_present;
      in_rc_q   <= evt_i.reason_code;
      in_perr_q <= evt_i.props_error;
      in_text_q <= evt_i.has_reason_text;
      in_user_q <= evt_i.has_user_props;
      in_link_q <= evt_i.link_ready;
    end
  end

  // Event decode. Every path ends in one result and one state update.
  logic [ReasonWidth-1:0] reason;
  logic                   props_bad;
  logic                   pid_match;
  logic                   rc_fail;
  logic                   limit_hit;
  logic [PidWidth-1:0]    start_pid;

  assign reason    = in_rp_q ? in_rc_q : '0;
  assign props_bad = in_perr_q || (!pia_q && (in_text_q || in_user_q));
  assign pid_match = (in_pid_q == held_pid_q);
  assign rc_fail   = (in_rc_q >= ReasonFail);
  assign limit_hit = (CmpWidth'(limit_q) <= CmpWidth'(sends_q));
  assign start_pid = (qos_q != Qos0) ? in_pid_q : '0;

  always_comb begin
    res_d         = '0;
    busy_d        = busy_q;
    gra_d         = gra_q;
    sends_d       = sends_q;
    held_pid_d    = held_pid_q;
    held_reason_d = held_reason_q;

    case (kind_e'(in_kind_q))
      KIND_START: begin
        if (busy_q) begin
          res_d.status = ST_REJECTED;
        end else if (qos_q == Qos3 || !in_link_q) begin
          res_d.finished = 1'b1;
          res_d.status   = ST_REJECTED;
        end else begin
          gra_d              = 1'b0;
          held_reason_d      = '0;
          held_pid_d         = start_pid;
          sends_d            = AttemptWidth'(1);
          res_d.tx_kind      = TX_PUBLISH;
          res_d.tx_packet_id = start_pid;
          if (qos_q == Qos0) begin
            // At QoS 0 the exchange completes without a response reason.
            res_d.finished = 1'b1;
            res_d.report   = 1'b1;
            res_d.status   = ST_COMPLETE;
          end else begin
            busy_d              = 1'b1;
            res_d.timer_restart = 1'b1;
          end
        end
      end

      KIND_ACK: begin
        if (busy_q && pid_match) begin
          busy_d         = 1'b0;
          res_d.finished = 1'b1;
          res_d.report   = 1'b1;
          if (qos_q != Qos1) begin
            res_d.status     = ST_PROTO;
            res_d.disconnect = 1'b1;
          end else begin
            // The alias is confirmed by a good reason even when the properties fail.
            res_d.confirm_alias = alias_q && (reason < ReasonFail);
            if (props_bad) begin
              res_d.status     = ST_PROTO;
              res_d.disconnect = 1'b1;
            end else begin
              res_d.status          = ST_COMPLETE;
              res_d.response_valid  = 1'b1;
              res_d.response_reason = reason;
            end
          end
        end
      end

      KIND_RECACK: begin
        if (busy_q && pid_match) begin
          if (qos_q != Qos2 || gra_q || props_bad) begin
            busy_d           = 1'b0;
            res_d.finished   = 1'b1;
            res_d.report     = 1'b1;
            res_d.status     = ST_PROTO;
            res_d.disconnect = 1'b1;
          end else if (in_rp_q && rc_fail) begin
            busy_d                = 1'b0;
            res_d.finished        = 1'b1;
            res_d.report          = 1'b1;
            res_d.status          = ST_COMPLETE;
            res_d.response_valid  = 1'b1;
            res_d.response_reason = in_rc_q;
          end else begin
            res_d.confirm_alias = alias_q;
            gra_d               = 1'b1;
            // The release restarts the transmission count.
            if (!in_link_q) begin
              sends_d        = '0;
              busy_d         = 1'b0;
              res_d.finished = 1'b1;
              res_d.report   = 1'b1;
              res_d.status   = ST_INTERNAL;
            end else begin
              sends_d             = AttemptWidth'(1);
              held_reason_d       = reason;
              res_d.tx_kind       = TX_RELEASE;
              res_d.tx_packet_id  = held_pid_q;
              res_d.timer_restart = 1'b1;
            end
          end
        end
      end

      KIND_COMPACK: begin
        if (busy_q && pid_match) begin
          busy_d         = 1'b0;
          res_d.finished = 1'b1;
          res_d.report   = 1'b1;
          if (qos_q != Qos2 || !gra_q || props_bad) begin
            res_d.status     = ST_PROTO;
            res_d.disconnect = 1'b1;
          end else begin
            // A zero or absent reason falls back to the one kept from the receive-ack.
            res_d.status          = ST_COMPLETE;
            res_d.response_valid  = 1'b1;
            res_d.response_reason = (in_rp_q && in_rc_q != '0) ? in_rc_q : held_reason_q;
          end
        end
      end

      KIND_TIMEOUT: begin
        if (busy_q) begin
          if (limit_hit) begin
            busy_d         = 1'b0;
            res_d.finished = 1'b1;
            res_d.report   = 1'b1;
            res_d.status   = ST_TIMEOUT;
          end else if (!in_link_q) begin
            busy_d         = 1'b0;
            res_d.finished = 1'b1;
            res_d.report   = 1'b1;
            res_d.status   = ST_INTERNAL;
          end else begin
            sends_d             = (sends_q == CntMax) ? sends_q : sends_q + 1'b1;
            res_d.tx_kind       = gra_q ? TX_RELEASE : TX_DUP;
            res_d.tx_packet_id  = held_pid_q;
            res_d.timer_restart = 1'b1;
          end
        end
      end

      KIND_CANCEL: begin
        if (busy_q) begin
          busy_d         = 1'b0;
          res_d.finished = 1'b1;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q        <= 1'b0;
      gra_q         <= 1'b0;
      sends_q       <= '0;
      held_pid_q    <= '0;
      held_reason_q <= '0;
    end else if (proc_fire) begin
      busy_q        <= busy_d;
      gra_q         <= gra_d;
      sends_q       <= sends_d;
      held_pid_q    <= held_pid_d;
      held_reason_q <= held_reason_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (proc_fire) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid           = res_valid_q;
  assign res_o.tx_kind         = res_q.tx_kind;
  assign res_o.tx_packet_id    = res_q.tx_packet_id;
  assign res_o.finished        = res_q.finished;
  assign res_o.report          = res_q.report;
  assign res_o.status          = res_q.status;
  assign res_o.response_valid  = res_q.response_valid;
  assign res_o.response_reason = res_q.response_reason;
  assign res_o.disconnect      = res_q.disconnect;
  assign res_o.confirm_alias   = res_q.confirm_alias;
  assign res_o.timer_restart   = res_q.timer_restart;

  // A finishing result always leaves the block idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc_fire && res_d.finished |=> !busy_q)
    else $error("block still busy after a finishing result");

  // A response reason is only offered with a reported completion.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.response_valid |-> res_q.report && res_q.status == ST_COMPLETE)
    else $error("response reason without reported completion");

  // The response timer restarts only when something was transmitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.timer_restart |-> res_q.tx_kind != TX_NONE && !res_q.finished)
    else $error("timer restart without a transmit");

endmodule

// ===== test/tb_publish_ack_handshake.sv =====
// Self-checking testbench for publish_ack_handshake: a directed table, then random exchanges.
// Each accepted event item is predicted in the testbench and every result item is compared
// field by field. Depends on pah_pkg, pah_evt_if, pah_res_if and the block itself.
`timescale 1ns / 100ps

module tb_publish_ack_handshake;
  import pah_pkg::*;

  // Kinds past the last event code; the block must ignore them.
  localparam logic [2:0] KindSpare6 = 3'd6;
  localparam logic [2:0] KindSpare7 = 3'd7;

  localparam int WatchdogLimit = 2000;  // cycles without any handshake
  localparam int LongHold      = 120;   // receiver hold-off, long enough to fill the block
  localparam int DrainCycles   = 8;     // extra wait after the final settle
  localparam int NumPhases     = 8;
  localparam int MaxReports    = 10;

  // One event item as it is driven onto the event channel. Exactly 32 bits wide, so a
  // single $urandom fills every field for noise items.
  typedef struct packed {
    logic [2:0]             kind;
    logic [PidWidth-1:0]    packet_id;
    logic                   reason_present;
    logic [ReasonWidth-1:0] reason_code;
    logic                   props_error;
    logic                   has_reason_text;
    logic                   has_user_props;
    logic                   link_ready;
  } evt_t;

  typedef struct packed {
    logic [1:0] qos_level;
    logic [7:0] attempt_limit;
    logic       problem_info_ok;
    logic       alias_registering;
  } cfg_t;

  // A row of the directed table: either a full register setting or one event item. Rows
  // with a typed result carry it in want; the others are checked against the predictor.
  typedef struct {
    bit      is_cfg;
    cfg_t    cfg;
    evt_t    evt;
    bit      typed;
    result_t want;
  } row_t;

  localparam result_t IgnoredResult = '0;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [CfgWidth-1:0]    cfg_data_i;

  pah_evt_if evt_if ();
  pah_res_if res_if ();

  publish_ack_handshake u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .evt_i      (evt_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Predictor copy of the exchange state and of the registers.
  cfg_t                    shadow = '{Qos0, 8'd2, 1'b1, 1'b0};
  logic                    xch_busy = 1'b0;
  logic                    xch_got_rack = 1'b0;
  logic [AttemptWidth-1:0] xch_sends = '0;
  logic [PidWidth-1:0]     xch_pid = '0;
  logic [ReasonWidth-1:0]  xch_reason = '0;

  result_t pending_results[$];
  row_t    stim_table[$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int errors = 0;
  int items_sent = 0;
  int useful_items = 0;
  int results_checked = 0;
  int phases_run = 0;
  int quiet_cycles = 0;

  // ---------------------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------------------

  function automatic void bump_sends();
    if (xch_sends != CntMax) xch_sends++;
  endfunction

  // Ends the exchange: the block goes idle and reports (or not) the given status.
  function automatic result_t closed(result_t r, status_e st, logic rep);
    r.finished = 1'b1;
    r.report   = rep;
    r.status   = st;
    xch_busy   = 1'b0;
    return r;
  endfunction

  function automatic result_t violation(result_t r);
    r = closed(r, ST_PROTO, 1'b1);
    r.disconnect = 1'b1;
    return r;
  endfunction

  function automatic result_t completed(result_t r, logic [ReasonWidth-1:0] rsn);
    r = closed(r, ST_COMPLETE, 1'b1);
    r.response_valid  = 1'b1;
    r.response_reason = rsn;
    return r;
  endfunction

  // A transmit that fails on a busy link ends the exchange with an internal error.
  function automatic result_t sent(result_t r, tx_kind_e tk, logic link);
    if (!link) return closed(r, ST_INTERNAL, 1'b1);
    r.tx_kind       = tk;
    r.tx_packet_id  = xch_pid;
    r.timer_restart = 1'b1;
    bump_sends();
    return r;
  endfunction

  function automatic logic props_bad(evt_t e);
    return e.props_error ||
           (!shadow.problem_info_ok && (e.has_reason_text || e.has_user_props));
  endfunction

  function automatic result_t exchange_outcome(evt_t e);
    result_t                r;
    logic [ReasonWidth-1:0] rsn;
    r   = '0;
    rsn = e.reason_present ? e.reason_code : '0;
    if (e.kind == KIND_START) begin
      if (xch_busy) begin
        r.status = ST_REJECTED;
      end else if (shadow.qos_level == Qos3 || !e.link_ready) begin
        r.finished = 1'b1;
        r.status   = ST_REJECTED;
      end else begin
        xch_got_rack   = 1'b0;
        xch_reason     = '0;
        xch_pid        = (shadow.qos_level != Qos0) ? e.packet_id : '0;
        xch_sends      = '0;
        r.tx_kind      = TX_PUBLISH;
        r.tx_packet_id = xch_pid;
        bump_sends();
        if (shadow.qos_level == Qos0) begin
          r = closed(r, ST_COMPLETE, 1'b1);
        end else begin
          xch_busy        = 1'b1;
          r.timer_restart = 1'b1;
        end
      end
    end else if (xch_busy && (e.kind == KIND_ACK || e.kind == KIND_RECACK ||
                              e.kind == KIND_COMPACK)) begin
      // Acknowledgements for another packet id are dropped without a trace.
      if (e.packet_id == xch_pid) begin
        if (e.kind == KIND_ACK) begin
          if (shadow.qos_level != Qos1) begin
            r = violation(r);
          end else begin
            // The alias is confirmed before the property check can still fail.
            if (shadow.alias_registering && rsn < ReasonFail) r.confirm_alias = 1'b1;
            r = props_bad(e) ? violation(r) : completed(r, rsn);
          end
        end else if (e.kind == KIND_RECACK) begin
          if (shadow.qos_level != Qos2 || xch_got_rack || props_bad(e)) begin
            r = violation(r);
          end else if (e.reason_present && e.reason_code >= ReasonFail) begin
            r = completed(r, e.reason_code);
          end else begin
            if (shadow.alias_registering) r.confirm_alias = 1'b1;
            xch_got_rack = 1'b1;
            xch_sends    = '0;
            r = sent(r, TX_RELEASE, e.link_ready);
            if (e.link_ready) xch_reason = rsn;
          end
        end else begin
          if (shadow.qos_level != Qos2 || !xch_got_rack || props_bad(e)) begin
            r = violation(r);
          end else begin
            r = completed(r, (e.reason_present && e.reason_code != '0) ? e.reason_code
                                                                      : xch_reason);
          end
        end
      end
    end else if (xch_busy && e.kind == KIND_TIMEOUT) begin
      if (shadow.attempt_limit <= xch_sends) begin
        r = closed(r, ST_TIMEOUT, 1'b1);
      end else begin
        r = sent(r, xch_got_rack ? TX_RELEASE : TX_DUP, e.link_ready);
      end
    end else if (xch_busy && e.kind == KIND_CANCEL) begin
      r = closed(r, ST_PENDING, 1'b0);
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Item builders
  // ---------------------------------------------------------------------------------------

  function automatic evt_t ev(logic [2:0] k, logic [PidWidth-1:0] pid,
                              logic rp = 1'b0, logic [ReasonWidth-1:0] rc = '0,
                              logic [2:0] flags = 3'b000, logic link = 1'b1);
    evt_t e;
    e.kind            = k;
    e.packet_id       = pid;
    e.reason_present  = rp;
    e.reason_code     = rc;
    e.props_error     = flags[2];
    e.has_reason_text = flags[1];
    e.has_user_props  = flags[0];
    e.link_ready      = link;
    return e;
  endfunction

  // An acknowledgement that mostly matches the running exchange and mostly succeeds.
  function automatic evt_t ack_like(logic [2:0] k, logic [PidWidth-1:0] pid);
    evt_t e;
    e.kind            = k;
    e.packet_id       = ($urandom_range(11) == 0) ? PidWidth'($urandom) : pid;
    e.reason_present  = 1'($urandom_range(1));
    e.reason_code     = ($urandom_range(2) == 0) ? ReasonWidth'($urandom)
                                                 : ReasonWidth'($urandom_range(8'h7F));
    e.props_error     = ($urandom_range(19) == 0);
    e.has_reason_text = ($urandom_range(7) == 0);
    e.has_user_props  = ($urandom_range(7) == 0);
    e.link_ready      = ($urandom_range(29) != 0);
    return e;
  endfunction

  function automatic evt_t tick();
    return ev(KIND_TIMEOUT, PidWidth'($urandom), 1'b0, '0, 3'b000, $urandom_range(29) != 0);
  endfunction

  function automatic result_t res_of(tx_kind_e tk, logic [PidWidth-1:0] pid, logic fin,
                                     logic rep, status_e st, logic timer);
    result_t r;
    r               = '0;
    r.tx_kind       = tk;
    r.tx_packet_id  = pid;
    r.finished      = fin;
    r.report        = rep;
    r.status        = st;
    r.timer_restart = timer;
    return r;
  endfunction

  function automatic row_t row_ev(evt_t e, bit typed = 1'b0, result_t want = '0);
    row_t row;
    row.is_cfg = 1'b0;
    row.cfg    = '0;
    row.evt    = e;
    row.typed  = typed;
    row.want   = want;
    return row;
  endfunction

  function automatic row_t row_cfg(logic [1:0] qos, logic [7:0] lim, logic pia, logic al);
    row_t row;
    row.is_cfg = 1'b1;
    row.cfg    = '{qos, lim, pia, al};
    row.evt    = '0;
    row.typed  = 1'b0;
    row.want   = '0;
    return row;
  endfunction

  // ---------------------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------------------

  // Offers one event item, waits for its handshake and records the expected result. The
  // valid line stays high on return so that the next item can follow without a gap.
  task automatic offer(evt_t e, bit typed = 1'b0, result_t want = '0);
    result_t r;
    while ($urandom_range(99) < src_idle_pct) begin
      evt_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    evt_if.valid           <= 1'b1;
    evt_if.kind            <= e.kind;
    evt_if.packet_id       <= e.packet_id;
    evt_if.reason_present  <= e.reason_present;
    evt_if.reason_code     <= e.reason_code;
    evt_if.props_error     <= e.props_error;
    evt_if.has_reason_text <= e.has_reason_text;
    evt_if.has_user_props  <= e.has_user_props;
    evt_if.link_ready      <= e.link_ready;
    do @(posedge clk_i); while (!evt_if.ready);
    r = exchange_outcome(e);
    pending_results.push_back(typed ? want : r);
    items_sent++;
    if (r != IgnoredResult) useful_items++;
  endtask

  // Stops offering and waits until every outstanding result has come back.
  task automatic settle();
    evt_if.valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  // Writes all four registers back to back; only called while nothing is in flight.
  task automatic program_regs(cfg_t c);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i  <= 1'b1;
      cfg_idx_i <= cfg_reg_e'(i);
      case (cfg_reg_e'(i))
        REG_QOS:          cfg_data_i <= CfgWidth'(c.qos_level);
        REG_ATTEMPT:      cfg_data_i <= c.attempt_limit;
        REG_PROBLEM_INFO: cfg_data_i <= CfgWidth'(c.problem_info_ok);
        default:          cfg_data_i <= CfgWidth'(c.alias_registering);
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    shadow = c;
    phases_run++;
  endtask

  // ---------------------------------------------------------------------------------------
  // Receiver: random stalls, plus one long hold-off when requested. The hold is counted
  // here so that the sender keeps pushing items into the block while it lasts.
  // ---------------------------------------------------------------------------------------
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_left = LongHold;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------------------
  // Result checking: every accepted result is matched against the oldest expectation.
  // ---------------------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= MaxReports)
        $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MaxReports)
          $display("%0t: result item arrived with no expectation waiting", $realtime);
      end else begin
        result_t want;
        want = pending_results.pop_front();
        compare_field("tx_kind",         want.tx_kind,         res_if.tx_kind);
        compare_field("tx_packet_id",    want.tx_packet_id,    res_if.tx_packet_id);
        compare_field("finished",        want.finished,        res_if.finished);
        compare_field("report",          want.report,          res_if.report);
        compare_field("status",          want.status,          res_if.status);
        compare_field("response_valid",  want.response_valid,  res_if.response_valid);
        compare_field("response_reason", want.response_reason, res_if.response_reason);
        compare_field("disconnect",      want.disconnect,      res_if.disconnect);
        compare_field("confirm_alias",   want.confirm_alias,   res_if.confirm_alias);
        compare_field("timer_restart",   want.timer_restart,   res_if.timer_restart);
        results_checked++;
      end
    end
  end

  // The run is stuck if neither channel moves for a long time.
  always @(posedge clk_i) begin
    if (!rst_ni || (evt_if.valid && evt_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WatchdogLimit) begin
      $display("Watchdog: no handshake for %0d cycles", WatchdogLimit);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------------------
  initial begin
    cfg_t                c;
    logic [PidWidth-1:0] pid;
    int                  budget;
    int                  phase_base;
    bit                  hold_done;

    evt_if.valid           <= 1'b0;
    evt_if.kind            <= KIND_START;
    evt_if.packet_id       <= '0;
    evt_if.reason_present  <= 1'b0;
    evt_if.reason_code     <= '0;
    evt_if.props_error     <= 1'b0;
    evt_if.has_reason_text <= 1'b0;
    evt_if.has_user_props  <= 1'b0;
    evt_if.link_ready      <= 1'b0;
    cfg_we_i               <= 1'b0;
    cfg_idx_i              <= REG_QOS;
    cfg_data_i             <= '0;
    hold_done = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table. It starts from the reset settings: QoS 0, two attempts, problem
    // info allowed, no alias registration.
    // Events while idle and kinds past the last code give an all-zero result.
    stim_table.push_back(row_ev(ev(KIND_ACK, 16'h0005), 1'b1, IgnoredResult));
    stim_table.push_back(row_ev(ev(KIND_CANCEL, 16'h0000), 1'b1, IgnoredResult));
    stim_table.push_back(row_ev(ev(KindSpare7, 16'hFFFF, 1'b1, 8'hFF, 3'b111), 1'b1,
                                IgnoredResult));
    // QoS 0: completes at once and the packet id is not used.
    stim_table.push_back(row_ev(ev(KIND_START, 16'hFFFF), 1'b1,
                                res_of(TX_PUBLISH, 16'h0000, 1'b1, 1'b1, ST_COMPLETE, 1'b0)));
    // Link not ready at start: rejected, finished, no report.
    stim_table.push_back(row_ev(ev(KIND_START, 16'h0001, 1'b0, '0, 3'b000, 1'b0), 1'b1,
                                res_of(TX_NONE, 16'h0000, 1'b1, 1'b0, ST_REJECTED, 1'b0)));

    stim_table.push_back(row_cfg(Qos1, 8'd2, 1'b1, 1'b1));
    stim_table.push_back(row_ev(ev(KIND_START, 16'hFFFF), 1'b1,
                                res_of(TX_PUBLISH, 16'hFFFF, 1'b0, 1'b0, ST_PENDING, 1'b1)));
    // A second start while busy is refused and the running exchange survives.
    stim_table.push_back(row_ev(ev(KIND_START, 16'h0000), 1'b1,
                                res_of(TX_NONE, 16'h0000, 1'b0, 1'b0, ST_REJECTED, 1'b0)));
    stim_table.push_back(row_ev(ev(KIND_ACK, 16'h1234), 1'b1, IgnoredResult));
    // A spare kind is ignored even while an exchange runs.
    stim_table.push_back(row_ev(ev(KindSpare6, 16'hFFFF), 1'b1, IgnoredResult));
    stim_table.push_back(row_ev(ev(KIND_TIMEOUT, 16'h0000)));
    // Two transmissions made with a limit of two: the next tick gives up.
    stim_table.push_back(row_ev(ev(KIND_TIMEOUT, 16'h0000), 1'b1,
                                res_of(TX_NONE, 16'h0000, 1'b1, 1'b1, ST_TIMEOUT, 1'b0)));
    stim_table.push_back(row_ev(ev(KIND_START, 16'h0000)));
    stim_table.push_back(row_ev(ev(KIND_ACK, 16'h0000, 1'b1, 8'h7F, 3'b011)));
    // Good reason on the ack but broken properties: alias still confirmed, then error.
    stim_table.push_back(row_ev(ev(KIND_START, 16'h0002)));
    stim_table.push_back(row_ev(ev(KIND_ACK, 16'h0002, 1'b1, 8'h10, 3'b100)));
    stim_table.push_back(row_ev(ev(KIND_START, 16'h0004)));
    stim_table.push_back(row_ev(ev(KIND_RECACK, 16'h0004)));
    stim_table.push_back(row_ev(ev(KIND_START, 16'h0005)));
    stim_table.push_back(row_ev(ev(KIND_CANCEL, 16'h0005), 1'b1,
                                res_of(TX_NONE, 16'h0000, 1'b1, 1'b0, ST_PENDING, 1'b0)));

    // A zero attempt limit ends the exchange on the first tick.
    stim_table.push_back(row_cfg(Qos2, 8'd0, 1'b0, 1'b1));
    stim_table.push_back(row_ev(ev(KIND_START, 16'hABCD)));
    stim_table.push_back(row_ev(ev(KIND_TIMEOUT, 16'h0000), 1'b1,
                                res_of(TX_NONE, 16'h0000, 1'b1, 1'b1, ST_TIMEOUT, 1'b0)));

    stim_table.push_back(row_cfg(Qos2, 8'hFF, 1'b0, 1'b1));
    // The release transmit fails after the alias has already been confirmed.
    stim_table.push_back(row_ev(ev(KIND_START, 16'h0007)));
    stim_table.push_back(row_ev(ev(KIND_RECACK, 16'h0007, 1'b0, '0, 3'b000, 1'b0)));
    // Release, a resent release, then a doubled receive-ack.
    stim_table.push_back(row_ev(ev(KIND_START, 16'h0008)));
    stim_table.push_back(row_ev(ev(KIND_RECACK, 16'h0008, 1'b1, 8'h05)));
    stim_table.push_back(row_ev(ev(KIND_TIMEOUT, 16'h0000)));
    stim_table.push_back(row_ev(ev(KIND_RECACK, 16'h0008)));
    // Complete-ack without a receive-ack before it.
    stim_table.push_back(row_ev(ev(KIND_START, 16'h0009)));
    stim_table.push_back(row_ev(ev(KIND_COMPACK, 16'h0009)));
    // User properties while problem info is not allowed.
    stim_table.push_back(row_ev(ev(KIND_START, 16'h000A)));
    stim_table.push_back(row_ev(ev(KIND_RECACK, 16'h000A, 1'b0, '0, 3'b001)));
    // A failure reason on the receive-ack ends the exchange as complete.
    stim_table.push_back(row_ev(ev(KIND_START, 16'h000B)));
    stim_table.push_back(row_ev(ev(KIND_RECACK, 16'h000B, 1'b1, 8'h80)));

    // QoS 3 cannot start at all.
    stim_table.push_back(row_cfg(Qos3, 8'hFF, 1'b1, 1'b0));
    stim_table.push_back(row_ev(ev(KIND_START, 16'h000C), 1'b1,
                                res_of(TX_NONE, 16'h0000, 1'b1, 1'b0, ST_REJECTED, 1'b0)));

    foreach (stim_table[i]) begin
      if (stim_table[i].is_cfg) begin
        settle();
        program_regs(stim_table[i].cfg);
      end else begin
        offer(stim_table[i].evt, stim_table[i].typed, stim_table[i].want);
      end
    end

    // Random part. Each phase sets the registers and an idling pattern, then runs mostly
    // well-formed exchanges with random content, mixed with noise items.
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      budget = 56;
      case (p)
        0: c = '{Qos1, 8'd1, 1'b1, 1'b1};
        1: c = '{Qos2, 8'd3, 1'b0, 1'b1};
        2: c = '{Qos2, 8'hFF, 1'b1, 1'b0};
        3: c = '{Qos1, 8'd0, 1'b0, 1'b0};
        4: begin
          c = '{Qos0, 8'd2, 1'b1, 1'b1};
          budget = 30;
        end
        5: c = '{Qos2, 8'($urandom_range(8, 1)), 1'($urandom_range(1)),
                 1'($urandom_range(1))};
        6: begin
          c = '{Qos3, 8'hFF, 1'b1, 1'b0};
          budget = 15;
        end
        default: c = '{Qos1, 8'($urandom_range(255, 1)), 1'($urandom_range(1)),
                       1'($urandom_range(1))};
      endcase
      program_regs(c);
      case (p % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 83; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 83; end
        default: begin src_idle_pct = 23; sink_stall_pct = 23; end
      endcase
      phase_base = useful_items;

      while (useful_items - phase_base < budget) begin
        if ($urandom_range(4) == 0) begin
          offer(evt_t'($urandom));
        end else begin
          pid = PidWidth'($urandom);
          offer(ev(KIND_START, pid, 1'b0, '0, 3'b000, $urandom_range(39) != 0));
          repeat ($urandom_range(2)) offer(tick());
          if (shadow.qos_level == Qos1) begin
            offer(ack_like(KIND_ACK, pid));
          end else if (shadow.qos_level == Qos2) begin
            offer(ack_like(KIND_RECACK, pid));
            repeat ($urandom_range(2)) offer(tick());
            if ($urandom_range(9) == 0) offer(ack_like(KIND_RECACK, pid));
            offer(ack_like(KIND_COMPACK, pid));
          end
        end
        // Once per run the receiver stops for a long stretch while items keep coming.
        if (p == 2 && !hold_done && useful_items - phase_base >= 20) begin
          hold_req  = 1'b1;
          hold_done = 1'b1;
        end
      end
    end

    settle();
    repeat (DrainCycles) @(posedge clk_i);
    errors += pending_results.size();

    $display("Sent %0d event items (%0d with an effect) over %0d register settings,",
             items_sent, useful_items, phases_run);
    $display("checked %0d result items under stall, idle and back-pressure patterns.",
             results_checked);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== publish_ack_handshake.f =====
hdl/pah_pkg.sv
hdl/pah_evt_if.sv
hdl/pah_res_if.sv
hdl/publish_ack_handshake.sv
test/tb_publish_ack_handshake.sv
